// ----- hw/rtl/rws_pkg.sv -----
package rws_pkg;

    localparam int RWS_MAX_PARTICLES = 256;

    localparam logic [8:0]  PCOUNT_RST   = 9'd256;
    localparam logic [3:0]  SUBSTEPS_RST = 4'd3;
    localparam logic [12:0] GAIN_RST     = 13'd4050;

    localparam logic [12:0] FORCE_K     = 13'h064;
    localparam logic [12:0] SELF_K      = 13'h7D0;
    localparam logic [31:0] ROUND_BIAS  = 32'd2048;
    localparam int          FORCE_SHIFT = 16;
    localparam int          DAMP_SHIFT  = 12;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_RELAX = 2'd2,
        ACT_DAMP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_PCOUNT   = 2'd0,
        CFG_SUBSTEPS = 2'd1,
        CFG_GAIN     = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_MUL,
        ALU_LAPL,
        ALU_SARD,
        ALU_RND
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_alu_req;

    typedef struct packed {
        t_action            action;
        logic [7:0]         index;
        logic [31:0]        height_in;
        logic [31:0]        velocity_in;
        logic signed [13:0] noise;
    } t_item;

    typedef struct packed {
        logic [31:0] height;
        logic [31:0] velocity;
    } t_result;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_DAMP_RD,
        S_DAMP_MUL,
        S_DAMP_RND,
        S_DAMP_ADD,
        S_DAMP_WR,
        S_SETUP0,
        S_SETUP1,
        S_SETUP2,
        S_F_RD,
        S_F_LAP,
        S_F_M1,
        S_F_M2,
        S_F_SD,
        S_F_AD,
        S_F_WR,
        S_I_RD,
        S_I_AD,
        S_I_WR,
        S_FETCH,
        S_CAPT
    } t_state;

endpackage

// ----- hw/rtl/rws_alu.sv -----
module rws_alu (
    input  logic              i_clk,
    input  rws_pkg::t_alu_req i_req,
    output logic [31:0]       o_y
);
    import rws_pkg::*;

    logic [31:0] r_y;
    logic [31:0] n_y;
    logic [31:0] diff;
    logic [31:0] biased;

    assign diff   = i_req.a - i_req.b;
    assign biased = i_req.a + ROUND_BIAS;

    always_comb begin
        case (i_req.op)
            ALU_ADD:  n_y = i_req.a + i_req.b;
            ALU_MUL:  n_y = i_req.a * 32'(i_req.b[12:0]);
            ALU_LAPL: n_y = i_req.a + i_req.b - {i_req.c[30:0], 1'b0};
            ALU_SARD: n_y = 32'($signed(diff) >>> FORCE_SHIFT);
            ALU_RND:  n_y = 32'($signed(biased) >>> DAMP_SHIFT);
            default:  n_y = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;

endmodule

// ----- hw/rtl/rws_seq.sv -----
module rws_seq #(
    parameter int MAX_PARTICLES = rws_pkg::RWS_MAX_PARTICLES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rws_pkg::t_item   i_item,
    output logic             o_idle,
    input  logic [8:0]       i_pcount,
    input  logic [3:0]       i_substeps,
    input  logic [12:0]      i_gain,
    output logic             o_res_valid,
    output rws_pkg::t_result o_res,
    input  logic             i_res_ready
);
    import rws_pkg::*;

    localparam int            AW        = $clog2(MAX_PARTICLES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PARTICLES - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_n, n_n;
    logic [AW-1:0] r_last, n_last;
    logic [3:0]    r_pass, n_pass;
    t_item         r_item, n_item;
    logic [31:0]   r_hl, n_hl;
    logic [31:0]   r_hc, n_hc;
    logic [31:0]   r_hr, n_hr;
    logic [31:0]   r_h0, n_h0;
    logic [31:0]   r_v, n_v;
    logic [31:0]   r_t, n_t;

    logic [31:0]   mem_h [MAX_PARTICLES];
    logic [31:0]   mem_v [MAX_PARTICLES];
    logic [31:0]   r_rd_h, r_rd_v;

    logic          h_we, v_we;
    logic [AW-1:0] h_waddr, v_waddr, h_raddr, v_raddr;
    logic [31:0]   h_wdata, v_wdata;

    t_alu_req      alu_req;
    logic [31:0]   w_y;

    logic          w_in_ok, w_ok;
    logic [AW-1:0] w_addr, w_last;
    logic [31:0]   w_nb;

    assign w_in_ok = 32'(i_item.index) < 32'(MAX_PARTICLES);
    assign w_ok    = 32'(r_item.index) < 32'(MAX_PARTICLES);
    assign w_addr  = AW'(r_item.index);
    assign w_last  = (32'(i_pcount) > 32'(MAX_PARTICLES)) ? LAST_ADDR
                                                          : AW'(i_pcount - 9'd1);
    // right neighbour wraps to the first particle
    assign w_nb    = (r_n == r_last) ? r_h0 : r_rd_h;

    rws_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_y   (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            mem_h[h_waddr] <= h_wdata;
        end
        r_rd_h <= mem_h[h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            mem_v[v_waddr] <= v_wdata;
        end
        r_rd_v <= mem_v[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_pass <= n_pass;
        r_item <= n_item;
        r_hl   <= n_hl;
        r_hc   <= n_hc;
        r_hr   <= n_hr;
        r_h0   <= n_h0;
        r_v    <= n_v;
        r_t    <= n_t;
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_last  = r_last;
        n_pass  = r_pass;
        n_item  = r_item;
        n_hl    = r_hl;
        n_hc    = r_hc;
        n_hr    = r_hr;
        n_h0    = r_h0;
        n_v     = r_v;
        n_t     = r_t;
        h_we    = 1'b0;
        v_we    = 1'b0;
        h_waddr = r_n;
        v_waddr = r_n;
        h_wdata = '0;
        v_wdata = '0;
        h_raddr = w_addr;
        v_raddr = w_addr;
        alu_req.op = ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        alu_req.c  = '0;
        case (r_state)
            S_CLEAR: begin
                h_we = 1'b1;
                v_we = 1'b1;
                if (r_n == LAST_ADDR) begin
                    n_n     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_n = r_n + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    case (i_item.action)
                        ACT_LOAD:  n_state = w_in_ok ? S_LOAD : S_FETCH;
                        ACT_READ:  n_state = S_FETCH;
                        ACT_DAMP:  n_state = w_in_ok ? S_DAMP_RD : S_FETCH;
                        ACT_RELAX: begin
                            if (i_pcount == 9'd0 || i_substeps == 4'd0) begin
                                n_state = S_FETCH;
                            end else begin
                                n_last  = w_last;
                                n_pass  = '0;
                                n_state = S_SETUP0;
                            end
                        end
                        default:   n_state = S_FETCH;
                    endcase
                end
            end
            S_LOAD: begin
                h_we    = 1'b1;
                v_we    = 1'b1;
                h_waddr = w_addr;
                v_waddr = w_addr;
                h_wdata = r_item.height_in;
                v_wdata = r_item.velocity_in;
                n_state = S_FETCH;
            end
            S_DAMP_RD: begin
                n_state = S_DAMP_MUL;
            end
            S_DAMP_MUL: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = r_rd_v;
                alu_req.b  = 32'(i_gain);
                n_state    = S_DAMP_RND;
            end
            S_DAMP_RND: begin
                alu_req.op = ALU_RND;
                alu_req.a  = w_y;
                n_state    = S_DAMP_ADD;
            end
            S_DAMP_ADD: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = w_y;
                alu_req.b  = 32'(r_item.noise);
                n_state    = S_DAMP_WR;
            end
            S_DAMP_WR: begin
                v_we    = 1'b1;
                v_waddr = w_addr;
                v_wdata = w_y;
                n_state = S_FETCH;
            end
            S_SETUP0: begin
                h_raddr = r_last;
                n_state = S_SETUP1;
            end
            S_SETUP1: begin
                n_hl    = r_rd_h;
                h_raddr = '0;
                n_state = S_SETUP2;
            end
            S_SETUP2: begin
                n_hc    = r_rd_h;
                n_h0    = r_rd_h;
                n_n     = '0;
                n_state = S_F_RD;
            end
            S_F_RD: begin
                h_raddr = r_n + AW'(1);
                v_raddr = r_n;
                n_state = S_F_LAP;
            end
            S_F_LAP: begin
                n_hr       = w_nb;
                n_v        = r_rd_v;
                alu_req.op = ALU_LAPL;
                alu_req.a  = r_hl;
                alu_req.b  = w_nb;
                alu_req.c  = r_hc;
                n_state    = S_F_M1;
            end
            S_F_M1: begin
                alu_req.op = ALU_MUL;
                alu_req.a  = w_y;
                alu_req.b  = 32'(FORCE_K);
                n_state    = S_F_M2;
            end
            S_F_M2: begin
                n_t        = w_y;
                alu_req.op = ALU_MUL;
                alu_req.a  = r_hc;
                alu_req.b  = 32'(SELF_K);
                n_state    = S_F_SD;
            end
            S_F_SD: begin
                alu_req.op = ALU_SARD;
                alu_req.a  = r_t;
                alu_req.b  = w_y;
                n_state    = S_F_AD;
            end
            S_F_AD: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_v;
                alu_req.b  = w_y;
                n_state    = S_F_WR;
            end
            S_F_WR: begin
                v_we    = 1'b1;
                v_wdata = w_y;
                // slide the neighbour window by one particle
                n_hl    = r_hc;
                n_hc    = r_hr;
                if (r_n == r_last) begin
                    n_n     = '0;
                    n_state = S_I_RD;
                end else begin
                    n_n     = r_n + AW'(1);
                    n_state = S_F_RD;
                end
            end
            S_I_RD: begin
                h_raddr = r_n;
                v_raddr = r_n;
                n_state = S_I_AD;
            end
            S_I_AD: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = r_rd_h;
                alu_req.b  = r_rd_v;
                n_state    = S_I_WR;
            end
            S_I_WR: begin
                h_we    = 1'b1;
                h_wdata = w_y;
                if (r_n == r_last) begin
                    n_n = '0;
                    if (r_pass == i_substeps - 4'd1) begin
                        n_state = S_FETCH;
                    end else begin
                        n_pass  = r_pass + 4'd1;
                        n_state = S_SETUP0;
                    end
                end else begin
                    n_n     = r_n + AW'(1);
                    n_state = S_I_RD;
                end
            end
            S_FETCH: begin
                n_state = S_CAPT;
            end
            S_CAPT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_CAPT);
    assign o_res.height   = w_ok ? r_rd_h : '0;
    assign o_res.velocity = w_ok ? r_rd_v : '0;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("item started outside idle");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_F_RD) || (r_state == S_I_RD)) |-> (r_n <= r_last))
        else $error("sweep index beyond active ring");

    a_height_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_we |-> ((r_state == S_CLEAR) || (r_state == S_LOAD) || (r_state == S_I_WR)))
        else $error("unexpected height write");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("result changed while waiting");

endmodule

// ----- hw/rtl/ring_wave_surface_step.sv -----
// relax passes are bound by the shared arithmetic unit and the single read port
// of each particle memory; the next word is taken in the cycle after the result
// leaves the sequencer
// reset: synchronous, active low; a clearing pass over all MAX_PARTICLES addresses
// zeroes both memories, no word is accepted until it ends
module ring_wave_surface_step #(
    parameter int MAX_PARTICLES = rws_pkg::RWS_MAX_PARTICLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // index, height_in, velocity_in, noise, zero pad
    input  logic [87:0] s_axis_tdata,
    // action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // height_out, velocity_out
    output logic [63:0] m_axis_tdata,
    // completed
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rws_pkg::*;

    logic [8:0]  r_pcount;
    logic [3:0]  r_substeps;
    logic [12:0] r_gain;
    logic        r_out_valid;
    t_result     r_out;

    t_item       w_item;
    logic        w_idle;
    logic        w_start;
    logic        w_res_valid;
    logic        w_res_ready;
    t_result     w_res;

    assign w_item.action      = t_action'(s_axis_tuser);
    assign w_item.index       = s_axis_tdata[7:0];
    assign w_item.height_in   = s_axis_tdata[39:8];
    assign w_item.velocity_in = s_axis_tdata[71:40];
    assign w_item.noise       = s_axis_tdata[85:72];

    assign s_axis_tready = w_idle;
    assign w_start       = s_axis_tvalid && w_idle;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount   <= PCOUNT_RST;
            r_substeps <= SUBSTEPS_RST;
            r_gain     <= GAIN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PCOUNT:   r_pcount   <= i_cfg_data[8:0];
                CFG_SUBSTEPS: r_substeps <= i_cfg_data[3:0];
                CFG_GAIN:     r_gain     <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    rws_seq #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (w_item),
        .o_idle      (w_idle),
        .i_pcount    (r_pcount),
        .i_substeps  (r_substeps),
        .i_gain      (r_gain),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // output register
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.velocity, r_out.height};
    assign m_axis_tuser  = 1'b1;

endmodule

// ----- sim/ring_wave_surface_step_tb.sv -----
`timescale 1ns / 100ps

module ring_wave_surface_step_tb;
    import rws_pkg::*;

    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          LONG_HOLD   = 300;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_WORDS = 46;
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;

    typedef struct {
        logic [7:0]  idx;
        t_action     act;
        logic [31:0] height;
        logic [31:0] velocity;
    } t_particle_exp;

    typedef struct {
        t_action     act;
        logic [7:0]  idx;
        logic [31:0] h;
        logic [31:0] v;
        logic [13:0] nz;
        bit          typed;
        logic [31:0] eh;
        logic [31:0] ev;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // predictor state
    logic [31:0] surf_h [0:RWS_MAX_PARTICLES-1];
    logic [31:0] surf_v [0:RWS_MAX_PARTICLES-1];
    logic [8:0]  reg_pcount;
    logic [3:0]  reg_substeps;
    logic [12:0] reg_gain;

    t_particle_exp particle_q[$];
    t_dir_row      dir_rows[$];

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_req;
    int hold_served;
    int hold_left;
    int fail_cnt;
    int cycle_cnt;

    ring_wave_surface_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] sar_k(logic [31:0] x, int sh);
        logic signed [31:0] s;
        s = x;
        return s >>> sh;
    endfunction

    task automatic relax_ring();
        int cnt;
        int l;
        int r;
        logic [31:0] c;
        logic [31:0] f0;
        logic [31:0] f1;
        cnt = (reg_pcount > RWS_MAX_PARTICLES) ? RWS_MAX_PARTICLES : int'(reg_pcount);
        if (cnt == 0) return;
        for (int s = 0; s < reg_substeps; s++) begin
            for (int n = 0; n < cnt; n++) begin
                l = (n == 0) ? cnt - 1 : n - 1;
                r = (n + 1 == cnt) ? 0 : n + 1;
                c = surf_h[n];
                f0 = 32'd100 * (surf_h[l] + surf_h[r] - (c << 1));
                f1 = 32'd2000 * c;
                surf_v[n] = surf_v[n] + sar_k(f0 - f1, 16);
            end
            for (int n = 0; n < cnt; n++)
                surf_h[n] = surf_h[n] + surf_v[n];
        end
    endtask

    task automatic apply_action(input t_action act, input logic [7:0] idx,
                                input logic [31:0] h, input logic [31:0] v,
                                input logic [13:0] nz,
                                output logic [31:0] rh, output logic [31:0] rv);
        logic [31:0] p;
        case (act)
            ACT_LOAD: begin
                surf_h[idx] = h;
                surf_v[idx] = v;
            end
            ACT_RELAX: begin
                relax_ring();
            end
            ACT_DAMP: begin
                p = surf_v[idx] * {19'd0, reg_gain} + ROUND_BIAS;
                surf_v[idx] = sar_k(p, DAMP_SHIFT) + {{18{nz[13]}}, nz};
            end
            default: begin
            end
        endcase
        rh = surf_h[idx];
        rv = surf_v[idx];
    endtask

    task automatic send_word(input t_action act, input logic [7:0] idx,
                             input logic [31:0] h, input logic [31:0] v,
                             input logic [13:0] nz, input bit typed,
                             input logic [31:0] eh, input logic [31:0] ev);
        logic [31:0] ph;
        logic [31:0] pv;
        t_particle_exp e;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {2'b00, nz, v, h, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_action(act, idx, h, v, nz, ph, pv);
        e.idx      = idx;
        e.act      = act;
        e.height   = typed ? eh : ph;
        e.velocity = typed ? ev : pv;
        particle_q.push_back(e);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (particle_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PCOUNT:   reg_pcount   = data[8:0];
            CFG_SUBSTEPS: reg_substeps = data[3:0];
            CFG_GAIN:     reg_gain     = data[12:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // upper bits beyond each register width carry junk
    task automatic set_regs(input int cnt, input int sub, input int gain);
        logic [15:0] junk;
        junk = 16'($urandom);
        cfg_write(CFG_PCOUNT, (16'(cnt) & 16'h01FF) | (junk & ~16'h01FF));
        junk = 16'($urandom);
        cfg_write(CFG_SUBSTEPS, (16'(sub) & 16'h000F) | (junk & ~16'h000F));
        junk = 16'($urandom);
        cfg_write(CFG_GAIN, (16'(gain) & 16'h1FFF) | (junk & ~16'h1FFF));
    endtask

    task automatic add_row(input t_action act, input logic [7:0] idx,
                           input logic [31:0] h, input logic [31:0] v,
                           input logic [13:0] nz, input bit typed,
                           input logic [31:0] eh, input logic [31:0] ev);
        t_dir_row row;
        row.act = act;
        row.idx = idx;
        row.h = h;
        row.v = v;
        row.nz = nz;
        row.typed = typed;
        row.eh = eh;
        row.ev = ev;
        dir_rows.push_back(row);
    endtask

    function automatic logic [31:0] rand_q12();
        if ($urandom_range(1) == 0) return $urandom;
        return 32'(int'($urandom_range(131071)) - 65536);
    endfunction

    function automatic logic [13:0] rand_noise();
        if ($urandom_range(4) == 0) return 14'($urandom);
        return 14'($urandom_range(8192) - 4096);
    endfunction

    function automatic logic [7:0] pick_index(int eff);
        if (eff > 0 && $urandom_range(9) < 8)
            return 8'($urandom_range(eff >= RWS_MAX_PARTICLES ? 255 : eff));
        return 8'($urandom_range(255));
    endfunction

    // receiver side
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_req) begin
            hold_served = hold_req;
            hold_left = LONG_HOLD;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_particle_exp e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (particle_q.size() == 0) begin
                $display("%0t: unexpected word, actual h %h v %h", $time,
                         m_axis_tdata[31:0], m_axis_tdata[63:32]);
                fail_cnt = fail_cnt + 1;
            end else begin
                e = particle_q.pop_front();
                if (m_axis_tdata[31:0] !== e.height) begin
                    $display("%0t: %s idx %0d height expected %h actual %h", $time,
                             e.act.name(), e.idx, e.height, m_axis_tdata[31:0]);
                    fail_cnt = fail_cnt + 1;
                end
                if (m_axis_tdata[63:32] !== e.velocity) begin
                    $display("%0t: %s idx %0d velocity expected %h actual %h", $time,
                             e.act.name(), e.idx, e.velocity, m_axis_tdata[63:32]);
                    fail_cnt = fail_cnt + 1;
                end
                if (m_axis_tuser !== 1'b1) begin
                    $display("%0t: %s idx %0d completed expected 1 actual %b", $time,
                             e.act.name(), e.idx, m_axis_tuser);
                    fail_cnt = fail_cnt + 1;
                end
            end
        end
    end

    initial begin
        static int ph_cnt  [NUM_PHASES] = '{3, 256, 0, 1, 2, 17, 511, 40};
        static int ph_sub  [NUM_PHASES] = '{1, 8, 0, 15, 2, 5, 3, 1};
        static int ph_gain [NUM_PHASES] = '{0, 4096, 8191, 4095, 1, 2048, 4050, 3000};
        int eff;
        int relax_pct;
        int big_left;
        int r;
        int mode;
        t_action act;
        t_dir_row row;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_READ;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_PCOUNT;
        i_cfg_data    = '0;
        snd_idle_pct  = 24;
        rcv_idle_pct  = 63;
        hold_req      = 0;
        hold_served   = 0;
        hold_left     = 0;
        fail_cnt      = 0;
        cycle_cnt     = 0;
        reg_pcount    = PCOUNT_RST;
        reg_substeps  = SUBSTEPS_RST;
        reg_gain      = GAIN_RST;
        for (int n = 0; n < RWS_MAX_PARTICLES; n++) begin
            surf_h[n] = '0;
            surf_v[n] = '0;
        end

        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of registers and store
        add_row(ACT_READ, 8'd0, '0, '0, '0, 1, 32'h0, 32'h0);
        add_row(ACT_READ, 8'd255, '1, '1, '1, 1, 32'h0, 32'h0);
        add_row(ACT_LOAD, 8'd0, 32'h7FFFFFFF, 32'h80000000, '0, 1,
                32'h7FFFFFFF, 32'h80000000);
        add_row(ACT_LOAD, 8'd255, 32'h80000000, 32'h7FFFFFFF, '0, 1,
                32'h80000000, 32'h7FFFFFFF);
        add_row(ACT_LOAD, 8'd1, 32'hFFFFFFFF, 32'h0, '0, 1, 32'hFFFFFFFF, 32'h0);
        add_row(ACT_DAMP, 8'd1, '0, '0, 14'h1000, 1, 32'hFFFFFFFF, 32'd4096);
        add_row(ACT_DAMP, 8'd1, '0, '0, 14'h3000, 1, 32'hFFFFFFFF, 32'hFFFFFFD2);
        // noise beyond the nominal range, product wrapping
        add_row(ACT_DAMP, 8'd0, '0, '0, 14'h1FFF, 1, 32'h7FFFFFFF, 32'd8191);
        add_row(ACT_DAMP, 8'd255, '0, '0, 14'h2000, 1, 32'h80000000, 32'hFFFFDFFF);
        add_row(ACT_LOAD, 8'd2, 32'h00001000, 32'h0, '0, 0, '0, '0);
        add_row(ACT_LOAD, 8'd128, 32'h00FF0000, 32'hFFFF8000, '0, 0, '0, '0);
        add_row(ACT_RELAX, 8'd0, '0, '0, '0, 0, '0, '0);
        add_row(ACT_READ, 8'd1, '0, '0, '0, 0, '0, '0);
        add_row(ACT_READ, 8'd2, '0, '0, '0, 0, '0, '0);
        add_row(ACT_READ, 8'd255, '0, '0, '0, 0, '0, '0);
        add_row(ACT_DAMP, 8'd2, '0, '0, 14'h0000, 0, '0, '0);
        add_row(ACT_LOAD, 8'd200, 32'h5A5AA5A5, 32'hA5A55A5A, 14'h2AAA, 1,
                32'h5A5AA5A5, 32'hA5A55A5A);
        add_row(ACT_READ, 8'd200, 32'hA5A55A5A, 32'h5A5AA5A5, 14'h1555, 1,
                32'h5A5AA5A5, 32'hA5A55A5A);
        add_row(ACT_RELAX, 8'd127, '0, '0, '0, 0, '0, '0);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_word(row.act, row.idx, row.h, row.v, row.nz, row.typed, row.eh, row.ev);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_regs(ph_cnt[p], ph_sub[p], ph_gain[p]);
            if (p == 0) cfg_write(CFG_UNUSED, 16'($urandom));
            mode = (p + 1) % 3;
            snd_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 63 : 0;
            rcv_idle_pct = (mode == 0) ? 63 : (mode == 1) ? 24 : 0;
            eff = (reg_pcount > RWS_MAX_PARTICLES) ? RWS_MAX_PARTICLES : int'(reg_pcount);
            relax_pct = (eff > 32) ? 4 : 15;
            big_left = 3;

            // seed the start of the ring, then mixed traffic
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k < 6 && k < eff) begin
                    send_word(ACT_LOAD, 8'(k), rand_q12(), rand_q12(), rand_noise(),
                              0, '0, '0);
                end else begin
                    r = $urandom_range(99);
                    if (r < relax_pct) act = ACT_RELAX;
                    else if (r < relax_pct + 30) act = ACT_LOAD;
                    else if (r < relax_pct + 55) act = ACT_READ;
                    else act = ACT_DAMP;
                    if (act == ACT_RELAX && eff > 32) begin
                        if (big_left == 0) act = ACT_READ;
                        else big_left = big_left - 1;
                    end
                    if (mode == 2 && k == 10) hold_req = hold_req + 1;
                    send_word(act, pick_index(eff), rand_q12(), rand_q12(), rand_noise(),
                              0, '0, '0);
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
